@@ design/frequency_ordered_list_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frequency ordered list core.
// All checks are clocked on i_clk and are off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_LIST_CORE_DEFINES_SVH
`define FREQUENCY_ORDERED_LIST_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define FOLC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the clock cycle after its antecedent.
`define FOLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define FOLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/folc_pkg.sv @@
// ----------------------------------------------------------------------------
// folc_pkg
// Shared types and constants of the frequency ordered list core.
// ----------------------------------------------------------------------------
package folc_pkg;

    // Default geometry of the list.
    localparam int DEPTH_DEF       = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Width of the running access number and of stored first-access stamps.
    localparam int ACCESS_W = 16;

    // Width of request kind and of the data values.
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

    // One request.
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    // One result of a dump.
    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        logic                      last;
    } t_rsp;

endpackage

@@ design/frequency_ordered_list_core.sv @@
// ----------------------------------------------------------------------------
// frequency_ordered_list_core
// Self-organizing list ordered by access count, built as a rotating row of
// entry registers with a single compare unit at the head.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An append never
// raises busy. An access keeps busy high through a search rotation, and on a
// hit through an insert rotation as well. A dump keeps busy high through one
// rotation and puts out one result per cycle, each on o_rsp for exactly one
// cycle with o_valid high. The first result is registered in r_rsp once the
// state has moved to dump, and the last one shows on the final busy cycle;
// the receiver must take every result as it comes. Every access and dump
// rotates the whole list through the head slot, one entry per cycle, since
// the single compare unit sits at the head slot: one rotation finds and
// removes the accessed entry, and on a hit a second rotation places it again.
// ----------------------------------------------------------------------------
`include "frequency_ordered_list_core_defines.svh"

module frequency_ordered_list_core #(
    parameter int DEPTH       = folc_pkg::DEPTH_DEF,
    parameter int COUNT_WIDTH = folc_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  folc_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_valid,
    output folc_pkg::t_rsp  o_rsp
);
    import folc_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);

    // One list entry.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_WIDTH-1:0]    count;
        logic                      visited;
        logic [ACCESS_W-1:0]       first;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_INSERT = 4'b0100,
        S_DUMP   = 4'b1000
    } t_state;

    // Moves of the entry row.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROT,
        OP_DROP,
        OP_PUSH
    } t_op;

    t_state               r_state, n_state;
    t_entry               r_slot [DEPTH];
    t_entry               n_slot [DEPTH];
    t_entry               r_hold, n_hold;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [LEN_W-1:0]     r_total, n_total;
    logic [LEN_W-1:0]     r_step, n_step;
    logic                 r_found, n_found;
    logic                 r_inserted, n_inserted;
    logic [ACCESS_W-1:0]  r_acc, n_acc;
    logic [ACCESS_W-1:0]  r_stamp, n_stamp;
    logic [VALUE_W-1:0]   r_key, n_key;
    logic                 r_valid, n_valid;
    t_rsp                 r_rsp, n_rsp;

    t_op                  slot_op;
    t_entry               push_entry;
    t_entry               hit_entry;
    logic                 key_hit;
    logic                 head_passes;
    logic [LEN_W-1:0]     remain;
    logic                 accept;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Compare unit at the head slot.
    assign key_hit     = (r_slot[0].value == $signed(r_key));
    assign head_passes = (r_slot[0].count > r_hold.count) ||
                         ((r_slot[0].count == r_hold.count) && r_slot[0].visited &&
                          (r_slot[0].first < r_hold.first));
    assign remain      = r_total - LEN_W'(1);

    // Head entry as it looks after this access.
    always_comb begin
        hit_entry = r_slot[0];
        if (r_slot[0].count != {COUNT_WIDTH{1'b1}}) begin
            hit_entry.count = r_slot[0].count + COUNT_WIDTH'(1);
        end
        if (!r_slot[0].visited) begin
            hit_entry.visited = 1'b1;
            hit_entry.first   = r_stamp;
        end
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_hold     = r_hold;
        n_len      = r_len;
        n_total    = r_total;
        n_step     = r_step;
        n_found    = r_found;
        n_inserted = r_inserted;
        n_acc      = r_acc;
        n_stamp    = r_stamp;
        n_key      = r_key;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        slot_op    = OP_HOLD;
        push_entry = r_hold;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_step  = '0;
                    n_total = r_len;
                    case (i_req.kind)
                        KIND_APPEND: begin
                            if (r_len < LEN_W'(DEPTH)) begin
                                push_entry.value   = i_req.value;
                                push_entry.count   = '0;
                                push_entry.visited = 1'b0;
                                push_entry.first   = '0;
                                slot_op            = OP_PUSH;
                                n_len              = r_len + LEN_W'(1);
                            end
                        end
                        KIND_ACCESS: begin
                            n_stamp = r_acc;
                            n_acc   = r_acc + ACCESS_W'(1);
                            n_key   = i_req.value;
                            n_found = 1'b0;
                            n_state = S_SEARCH;
                        end
                        KIND_DUMP: begin
                            n_state = S_DUMP;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // First rotation: find the first match and take it out of the row.
            S_SEARCH: begin
                if (r_step == r_total) begin
                    n_step     = '0;
                    n_inserted = 1'b0;
                    n_state    = r_found ? S_INSERT : S_IDLE;
                end else begin
                    n_step = r_step + LEN_W'(1);
                    if (!r_found && key_hit) begin
                        n_hold  = hit_entry;
                        n_found = 1'b1;
                        slot_op = OP_DROP;
                        n_len   = r_len - LEN_W'(1);
                    end else begin
                        slot_op = OP_ROT;
                    end
                end
            end

            // Second rotation: put the held entry before the first one it
            // does not pass.
            S_INSERT: begin
                if (r_inserted && (r_step == remain)) begin
                    n_state = S_IDLE;
                end else if (!r_inserted && ((r_step == remain) || !head_passes)) begin
                    slot_op    = OP_PUSH;
                    n_len      = r_len + LEN_W'(1);
                    n_inserted = 1'b1;
                end else begin
                    slot_op = OP_ROT;
                    n_step  = r_step + LEN_W'(1);
                end
            end

            // Dump: emit the head entry on each rotation step.
            S_DUMP: begin
                if (r_step == r_total) begin
                    n_state = S_IDLE;
                end else begin
                    slot_op           = OP_ROT;
                    n_step            = r_step + LEN_W'(1);
                    n_valid           = 1'b1;
                    n_rsp.entry_value = r_slot[0].value;
                    n_rsp.last        = (r_step == remain);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry row moves: rotate, drop the head, or write at the tail.
    always_comb begin
        n_slot = r_slot;
        case (slot_op)
            OP_ROT: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_slot[i] = r_slot[i + 1];
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (LEN_W'(i) == r_len - LEN_W'(1)) begin
                        n_slot[i] = r_slot[0];
                    end
                end
            end
            OP_DROP: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_slot[i] = r_slot[i + 1];
                end
            end
            OP_PUSH: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (LEN_W'(i) == r_len) begin
                        n_slot[i] = push_entry;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_acc      <= '0;
            r_valid    <= 1'b0;
            r_step     <= '0;
            r_total    <= '0;
            r_found    <= 1'b0;
            r_inserted <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_acc      <= n_acc;
            r_valid    <= n_valid;
            r_step     <= n_step;
            r_total    <= n_total;
            r_found    <= n_found;
            r_inserted <= n_inserted;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_hold  <= n_hold;
        r_stamp <= n_stamp;
        r_key   <= n_key;
        r_rsp   <= n_rsp;
    end

    // Checks.
    `FOLC_ASSERT_ALWAYS(a_len_bound, r_len <= LEN_W'(DEPTH), "list length beyond depth")
    `FOLC_ASSERT_NEXT(a_valid_from_dump, n_valid, $past(r_state) == S_DUMP, "result outside dump")
    `FOLC_ASSERT_NEXT(a_append_grows, accept && (i_req.kind == KIND_APPEND) && (r_len < LEN_W'(DEPTH)), r_len == $past(r_len) + LEN_W'(1), "append did not grow list")
    `FOLC_ASSERT_SAME(a_insert_len, (r_state == S_INSERT) && !r_inserted, r_len == remain, "held entry not removed")

endmodule
